// File: hw/rtl/fwa_pkg.sv
// Shared types, constants and the elaboration-time Fermi table builder
// for the Fermi weight accumulator. No dependencies.
package fwa_pkg;

    localparam int ENERGY_W  = 32;
    localparam int CFG_W     = 24;
    localparam int WEIGHT_W  = 17;
    localparam int SUM_W     = 37;
    localparam int COUNT_W   = 21;
    localparam int CFG_IDX_W = 8;
    localparam int FRAC_W    = 21;

    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [SUM_W-1:0]    SUM_LIMIT = 37'h10_0000_0000;
    localparam longint              SPAN_HALF = 64'sd1048576;

    localparam logic [CFG_W-1:0] BETA_RESET   = 24'd109227;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BETA   = 8'd0,
        CFG_OFFSET = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy_self;
        logic signed [ENERGY_W-1:0] energy_other;
        logic                       last_sample;
    } sample_t;

    typedef struct packed {
        logic [SUM_W-1:0]   weight_sum;
        logic [COUNT_W-1:0] sample_count;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last_sample;
    } item_t;

    // Restoring long division; evaluated only while building the table.
    function automatic logic [63:0] build_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid point 1/(1+exp(x)) in Q1.16 for x in Q16.16.
    function automatic logic [WEIGHT_W-1:0] fermi_point(input longint xq);
        logic [63:0] a;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] even;
        logic [63:0] odd;
        logic [63:0] e;
        logic [63:0] w;
        logic [63:0] one_q30;
        one_q30 = 64'd1 << 30;
        a    = (xq < 0) ? 64'(-xq) : 64'(xq);
        y    = a << 10;
        term = one_q30;
        even = one_q30;
        odd  = '0;
        for (int n = 1; n <= 24; n++) begin
            term = build_udiv((term * y) >> 30, 64'(n));
            if (n % 2 == 1)
                odd = odd + term;
            else
                even = even + term;
        end
        e = (even > odd) ? even - odd : 64'd0;
        for (int k = 0; k < 4; k++)
            e = (e * e) >> 30;
        w = build_udiv((e << 16) + ((one_q30 + e) >> 1), one_q30 + e);
        return (xq < 0) ? WEIGHT_W'(64'd65536 - w) : WEIGHT_W'(w);
    endfunction

endpackage

// File: hw/rtl/fwa_fifo.sv
// Small register FIFO used as the item queue and the result queue.
// Depends on nothing.
module fwa_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        level_next = level_reg + LW'(do_push) - LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("fifo push while full");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(DEPTH))
        else $error("fifo level out of range");

endmodule

// File: hw/rtl/fwa_front.sv
// Front pipeline: energy difference, scaling by beta, table lookup and
// interpolation of the Fermi weight. Depends on fwa_pkg.
module fwa_front
    import fwa_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  sample_t          sample,
    input  logic [CFG_W-1:0] beta,
    input  logic [CFG_W-1:0] offset,
    output logic             item_push,
    output item_t            item
);

    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = FRAC_W + IW;

    logic [WEIGHT_W-1:0] fermi_rom [TABLE_DEPTH+1];

    for (genvar i = 0; i <= TABLE_DEPTH; i++)
    begin : g_rom
        localparam longint XQ = ((64'(i) << FRAC_W) / TABLE_DEPTH) - SPAN_HALF;
        localparam logic [WEIGHT_W-1:0] POINT = fermi_point(XQ);
        assign fermi_rom[i] = POINT;
    end

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  last1_reg, last2_reg, last3_reg, last4_reg;
    logic signed [32:0]    diff_reg, diff_next;
    logic signed [57:0]    prod_reg, prod_next;
    logic signed [41:0]    q;
    logic signed [42:0]    x;
    logic [FRAC_W-1:0]     pos;
    logic [SW-1:0]         s;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         idx_inc;
    logic [FRAC_W-1:0]     f3_reg, f4_reg;
    logic                  below3_reg, above3_reg, below4_reg, above4_reg;
    logic [WEIGHT_W-1:0]   t0, t1;
    logic [WEIGHT_W-1:0]   t0_reg, d_reg, d_next;
    logic [37:0]           interp;
    logic [WEIGHT_W-1:0]   weight;

    assign diff_next = 33'(sample.energy_other) - 33'(sample.energy_self);
    assign prod_next = diff_reg * $signed({1'b0, beta});

    assign q   = 42'(prod_reg >>> 16);
    assign x   = 43'(q) - 43'($signed(offset));
    assign pos = FRAC_W'(x + 43'(SPAN_HALF));
    assign s   = SW'(pos) * SW'(TABLE_DEPTH);
    assign idx_next = s[SW-1:FRAC_W];

    assign idx_inc = idx_reg + IW'(1);
    assign t0      = fermi_rom[idx_reg];
    assign t1      = (fermi_rom[idx_inc] > t0) ? t0 : fermi_rom[idx_inc];
    assign d_next  = t0 - t1;

    assign interp = 38'(d_reg) * 38'(f4_reg);

    always_comb
    begin
        if (below4_reg)
            weight = ONE_Q16;
        else if (above4_reg)
            weight = '0;
        else
            weight = t0_reg - WEIGHT_W'(interp >> FRAC_W);
    end

    assign item_push        = v4_reg;
    assign item.weight      = weight;
    assign item.last_sample = last4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        last1_reg  <= sample.last_sample;
        prod_reg   <= prod_next;
        last2_reg  <= last1_reg;
        idx_reg    <= idx_next;
        f3_reg     <= s[FRAC_W-1:0];
        below3_reg <= (x < -43'(SPAN_HALF));
        above3_reg <= (x >= 43'(SPAN_HALF));
        last3_reg  <= last2_reg;
        t0_reg     <= t0;
        d_reg      <= d_next;
        f4_reg     <= f3_reg;
        below4_reg <= below3_reg;
        above4_reg <= above3_reg;
        last4_reg  <= last3_reg;
    end

endmodule

// File: hw/rtl/fwa_back.sv
// Back end: saturating accumulation of weights and sample count, and
// emission of the result on the last sample. Depends on fwa_pkg.
module fwa_back
    import fwa_pkg::*;
#(
    parameter int COUNT_LOG2 = 20
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_ready,
    input  item_t   item,
    output logic    item_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    localparam int CW = COUNT_LOG2 + 1;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(1) << COUNT_LOG2;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             sat_reg, sat_next;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_new;
    logic [CW-1:0]    count_new;
    logic             sat_new;

    assign item_pop = item_ready && !res_full;
    assign sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(item.weight);

    always_comb
    begin
        sat_new = sat_reg;
        if (sum_add > (SUM_W+1)'(SUM_LIMIT))
        begin
            sum_new = SUM_LIMIT;
            sat_new = 1'b1;
        end
        else
        begin
            sum_new = SUM_W'(sum_add);
        end
        if (count_reg >= COUNT_LIMIT)
        begin
            count_new = COUNT_LIMIT;
            sat_new   = 1'b1;
        end
        else
        begin
            count_new = count_reg + CW'(1);
        end

        sum_next   = sum_reg;
        count_next = count_reg;
        sat_next   = sat_reg;
        if (item_pop)
        begin
            if (item.last_sample)
            begin
                sum_next   = '0;
                count_next = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_new;
                count_next = count_new;
                sat_next   = sat_new;
            end
        end
    end

    assign res_push         = item_pop && item.last_sample;
    assign res.weight_sum   = sum_new;
    assign res.sample_count = COUNT_W'(count_new);
    assign res.overflowed   = sat_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            sat_reg   <= sat_next;
        end
    end

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_LIMIT)
        else $error("running sum above limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("running count above limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (sum_reg == '0 && count_reg == '0 && !sat_reg))
        else $error("state not cleared after last sample");

endmodule

// File: hw/rtl/fermi_weight_accumulator_top.sv
// Top level of the Fermi weight accumulator: configuration registers,
// front pipeline, item queue, back end and result queue.
// Depends on fwa_pkg, fwa_fifo, fwa_front and fwa_back.
// Usage:
//   Input channel: drive sample and raise push; a sample transfers on a
//   rising edge with push high and full low. One sample per cycle is taken.
//   Result channel: while empty is low the oldest result is on result;
//   raise pop to take it. A result appears only for a sample marked last.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is beta, index 1 the offset constant, other indexes are dropped.
//   cfg_ready is always high. Write only while no sample is in flight.
// Data path:
//   A sample passes four front pipeline stages (difference, beta product,
//   table index, interpolation), then the item queue; the back end adds it
//   at the edge that pops it, held off while the result queue is full, and
//   a last sample's result enters the result queue at that same edge.
//   Sustained rate is one sample per cycle while the result side keeps up.
// Reset clears the sums, queues and pipeline and reloads the default beta
// and offset. When the result side stalls the back end holds, the item queue
// fills, and full rises once eight samples are in flight.
module fermi_weight_accumulator_top
    import fwa_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_LOG2  = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sample_t              sample,
    output logic                 full,
    input  logic                 pop,
    output result_t              result,
    output logic                 empty,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int MID_DEPTH = 8;
    localparam int RES_DEPTH = 2;
    localparam int FW        = $clog2(MID_DEPTH + 1);

    logic [CFG_W-1:0] beta_reg, beta_next;
    logic [CFG_W-1:0] offset_reg, offset_next;
    logic [FW-1:0]    inflight_reg, inflight_next;
    logic             accept;
    logic             item_push;
    item_t            item_in;
    item_t            item_out;
    logic             mid_full;
    logic             mid_empty;
    logic             item_pop;
    logic             res_push;
    logic             res_full;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign full      = (inflight_reg == FW'(MID_DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        beta_next   = beta_reg;
        offset_next = offset_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BETA:   beta_next   = cfg_data;
                CFG_OFFSET: offset_next = cfg_data;
                default:    ;
            endcase
        end
        inflight_next = inflight_reg + FW'(accept) - FW'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg     <= BETA_RESET;
            offset_reg   <= OFFSET_RESET;
            inflight_reg <= '0;
        end
        else
        begin
            beta_reg     <= beta_next;
            offset_reg   <= offset_next;
            inflight_reg <= inflight_next;
        end
    end

    fwa_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .beta      (beta_reg),
        .offset    (offset_reg),
        .item_push (item_push),
        .item      (item_in)
    );

    fwa_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (item_in),
        .full  (mid_full),
        .pop   (item_pop),
        .rdata (item_out),
        .empty (mid_empty)
    );

    fwa_back #(
        .COUNT_LOG2 (COUNT_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ready (!mid_empty),
        .item       (item_out),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    fwa_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FW'(MID_DEPTH))
        else $error("in-flight count out of range");

    a_mid_never_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        item_push |-> !mid_full)
        else $error("item queue overrun");

endmodule

// File: verif/fermi_weight_accumulator_top_test.sv
// Self-checking testbench for fermi_weight_accumulator_top: a scoreboard class
// predicts each set's weight sum, sample count and overflow flag.
// Depends on fwa_pkg and the fermi_weight_accumulator_top RTL.
`timescale 1ns / 1ps

module fermi_weight_accumulator_top_test;
    import fwa_pkg::*;

    localparam int          TABLE_SIZE      = 256;
    localparam int          COUNT_BITS      = 20;
    localparam logic [63:0] COUNT_LIMIT     = 64'd1 << COUNT_BITS;
    localparam logic [63:0] ONE_Q30         = 64'd1 << 30;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int          PRESSURE_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          PHASES          = 10;
    localparam int          PHASE_ITEMS     = 170;
    localparam int          FULL_RUN        = 24;

    localparam int E_MIN = 32'sh8000_0000;
    localparam int E_MAX = 32'sh7FFF_FFFF;

    localparam logic [CFG_W-1:0] BETA_ONE        = 24'h01_0000;
    localparam logic [CFG_W-1:0] BETA_MAX        = 24'hFF_FFFF;
    localparam logic [CFG_W-1:0] BETA_ZERO       = 24'h00_0000;
    localparam logic [CFG_W-1:0] OFFSET_MIN      = 24'h80_0000;
    localparam logic [CFG_W-1:0] OFFSET_MAX      = 24'h7F_FFFF;
    localparam logic [CFG_W-1:0] OFFSET_HALF_NEG = 24'hF8_0000;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP   = 8'hFF;

    class fermi_sum_board;
        logic [CFG_W-1:0]    beta_reg;
        logic [CFG_W-1:0]    offset_reg;
        logic [63:0]         sum_acc;
        logic [63:0]         count_acc;
        bit                  sat_seen;
        logic [WEIGHT_W-1:0] sig_points [0:TABLE_SIZE];
        result_t             expected_sums [$];
        int                  fails;

        function new();
            for (int i = 0; i <= TABLE_SIZE; i++)
                sig_points[i] = sigmoid_at(longint'((i * 64'd2097152) / TABLE_SIZE)
                                           - SPAN_HALF);
            beta_reg   = BETA_RESET;
            offset_reg = OFFSET_RESET;
            sum_acc    = '0;
            count_acc  = '0;
            sat_seen   = 1'b0;
            fails      = 0;
        endfunction

        function logic [WEIGHT_W-1:0] sigmoid_at(longint xq);
            longint      a;
            logic [63:0] y;
            logic [63:0] term;
            logic [63:0] evens;
            logic [63:0] odds;
            logic [63:0] e;
            logic [63:0] w;
            a     = (xq < 0) ? -xq : xq;
            y     = 64'(a) << 10;
            term  = ONE_Q30;
            evens = ONE_Q30;
            odds  = '0;
            for (int n = 1; n <= 24; n++)
            begin
                term = ((term * y) >> 30) / 64'(n);
                if (n % 2 == 1)
                    odds = odds + term;
                else
                    evens = evens + term;
            end
            e = (evens > odds) ? evens - odds : 64'd0;
            repeat (4)
                e = (e * e) >> 30;
            w = ((e << 16) + ((ONE_Q30 + e) >> 1)) / (ONE_Q30 + e);
            return (xq < 0) ? WEIGHT_W'(64'(ONE_Q16) - w) : WEIGHT_W'(w);
        endfunction

        function logic [WEIGHT_W-1:0] weight_of(longint x);
            logic [63:0] pos;
            logic [63:0] s;
            logic [63:0] idx;
            logic [63:0] frac;
            logic [63:0] t0;
            logic [63:0] t1;
            if (x < -SPAN_HALF)
                return ONE_Q16;
            if (x >= SPAN_HALF)
                return '0;
            pos  = 64'(x + SPAN_HALF);
            s    = pos * TABLE_SIZE;
            idx  = s >> FRAC_W;
            frac = s & ((64'd1 << FRAC_W) - 1);
            if (idx >= TABLE_SIZE)
                idx = TABLE_SIZE - 1;
            t0 = sig_points[idx];
            t1 = sig_points[idx + 1];
            if (t1 > t0)
                t1 = t0;
            return WEIGHT_W'(t0 - (((t0 - t1) * frac) >> FRAC_W));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_BETA)
                beta_reg = data;
            else if (idx == CFG_OFFSET)
                offset_reg = data;
        endfunction

        function void add_sample(sample_t smp);
            longint  diff;
            longint  prod;
            longint  xq;
            result_t r;
            diff = longint'($signed(smp.energy_other)) - longint'($signed(smp.energy_self));
            prod = diff * longint'(beta_reg);
            xq   = (prod >>> 16) - longint'($signed(offset_reg));
            sum_acc = sum_acc + weight_of(xq);
            if (sum_acc > SUM_LIMIT)
            begin
                sum_acc  = SUM_LIMIT;
                sat_seen = 1'b1;
            end
            if (count_acc >= COUNT_LIMIT)
            begin
                count_acc = COUNT_LIMIT;
                sat_seen  = 1'b1;
            end
            else
                count_acc = count_acc + 1;
            if (smp.last_sample)
            begin
                r.weight_sum   = sum_acc[SUM_W-1:0];
                r.sample_count = count_acc[COUNT_W-1:0];
                r.overflowed   = sat_seen;
                expected_sums.push_back(r);
                sum_acc   = '0;
                count_acc = '0;
                sat_seen  = 1'b0;
            end
        endfunction

        function void check_sum(result_t got);
            result_t want;
            if (expected_sums.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("%0t unexpected result: weight_sum %0d sample_count %0d %s %0d",
                             $time, got.weight_sum, got.sample_count, "overflowed",
                             got.overflowed);
                return;
            end
            want = expected_sums[0];
            expected_sums.delete(0);
            if (got.weight_sum !== want.weight_sum || got.sample_count !== want.sample_count ||
                got.overflowed !== want.overflowed)
            begin
                fails++;
                if (fails <= 10)
                    $display("%0t mismatch (exp/act): weight_sum %0d/%0d %s %0d/%0d %s %0d/%0d",
                             $time, want.weight_sum, got.weight_sum,
                             "sample_count", want.sample_count, got.sample_count,
                             "overflowed", want.overflowed, got.overflowed);
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    sample_t              sample    = '0;
    logic                 full;
    logic                 pop       = 1'b0;
    result_t              result;
    logic                 empty;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    fermi_sum_board board;
    bit             steady    = 1'b0;
    bit             stall_req = 1'b0;
    bit             holding   = 1'b0;
    int             quiet     = 0;

    fermi_weight_accumulator_top #(
        .TABLE_DEPTH(TABLE_SIZE),
        .COUNT_LOG2 (COUNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .pop      (pop),
        .result   (result),
        .empty    (empty),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (push && !full)
                board.add_sample(sample);
            if (pop && !empty)
                board.check_sum(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function automatic sample_t pair(int es, int eo, bit last);
        sample_t s;
        s.energy_self  = es;
        s.energy_other = eo;
        s.last_sample  = last;
        return s;
    endfunction

    function automatic sample_t random_sample(bit last);
        sample_t s;
        int      roll;
        int      base;
        int      delta;
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            s.energy_self  = $urandom;
            s.energy_other = $urandom;
        end
        else
        begin
            base = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            if (roll < 70)
                delta = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            else
                delta = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            s.energy_self  = base;
            s.energy_other = base + delta;
        end
        s.last_sample = last;
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain_results();
        int gap;
        forever
        begin
            if (stall_req)
            begin
                pop     <= 1'b0;
                holding = 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                holding   = 1'b0;
                stall_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 || !empty)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] beta, input logic [CFG_W-1:0] offset);
        wait_idle();
        set_reg(CFG_BETA, beta);
        set_reg(CFG_OFFSET, offset);
        set_reg(CFG_IDX_W'($urandom_range(IDX_SPARE, IDX_TOP)), CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] beta;
        logic [CFG_W-1:0] offset;
        int               left;
        int               len;
        int               roll;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        send_sample(pair(0, 0, 1'b0));
        send_sample(pair(E_MIN, E_MAX, 1'b0));
        send_sample(pair(E_MAX, E_MIN, 1'b0));
        send_sample(pair(E_MAX, E_MAX, 1'b0));
        send_sample(pair(E_MIN, E_MIN, 1'b1));
        send_sample(pair(5, 5, 1'b1));

        // unit beta: probe both span edges and the interpolation
        write_config(BETA_ONE, OFFSET_RESET);
        send_sample(pair(32'h0010_0000, 0, 1'b0));
        send_sample(pair(32'h0010_0001, 0, 1'b0));
        send_sample(pair(0, 32'h000F_FFFF, 1'b0));
        send_sample(pair(0, 32'h0010_0000, 1'b0));
        send_sample(pair(0, 1, 1'b0));
        send_sample(pair(1, 0, 1'b0));
        send_sample(pair(0, 4096, 1'b1));

        write_config(BETA_MAX, OFFSET_MIN);
        send_sample(pair($urandom, $urandom, 1'b0));
        send_sample(pair(0, 0, 1'b0));
        send_sample(pair(E_MIN, E_MAX, 1'b1));

        write_config(BETA_ZERO, OFFSET_MAX);
        send_sample(pair(E_MAX, E_MIN, 1'b0));
        send_sample(pair(0, 0, 1'b1));

        write_config(BETA_ZERO, OFFSET_MIN);
        send_sample(pair(0, 0, 1'b1));

        write_config(BETA_ONE, OFFSET_HALF_NEG);
        send_sample(pair(0, 0, 1'b1));

        // one set of full weights sent back to back
        write_config(BETA_ONE, OFFSET_RESET);
        steady = 1'b1;
        for (int i = 0; i < FULL_RUN; i++)
            send_sample(pair(0, -32'sh0020_0000, i == FULL_RUN - 1));
        steady = 1'b0;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            roll = $urandom_range(0, 99);
            case (phase)
                0: begin beta = BETA_MAX;   offset = OFFSET_MIN;   end
                1: begin beta = BETA_ZERO;  offset = OFFSET_MAX;   end
                2: begin beta = BETA_RESET; offset = OFFSET_RESET; end
                default:
                begin
                    beta   = (roll < 50) ? CFG_W'($urandom_range(32'h4000, 32'h4_0000))
                                         : CFG_W'($urandom);
                    offset = (roll < 60) ? CFG_W'($urandom_range(0, 32'h20_0000) - 32'h10_0000)
                                         : CFG_W'($urandom);
                end
            endcase
            write_config(beta, offset);
            left = PHASE_ITEMS;
            if (phase == 4)
            begin
                // hold the result side and keep offering until full
                stall_req = 1'b1;
                wait (holding);
                steady = 1'b1;
                repeat (64)
                    send_sample(random_sample(1'b1));
                steady = 1'b0;
                left = left - 64;
            end
            while (left > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    len = $urandom_range(1, 8);
                else if (roll < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 150);
                if (len > left)
                    len = left;
                steady = ($urandom_range(0, 9) == 0);
                for (int j = 0; j < len; j++)
                    send_sample(random_sample(j == len - 1));
                left = left - len;
            end
            steady = 1'b0;
        end

        wait_idle();
        if (board.fails == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fwa_pkg.sv
hw/rtl/fwa_fifo.sv
hw/rtl/fwa_front.sv
hw/rtl/fwa_back.sv
hw/rtl/fermi_weight_accumulator_top.sv
verif/fermi_weight_accumulator_top_test.sv
